// ===== hw/rtl/rdrs_pkg.sv =====
`default_nettype none

package rdrs_pkg;

  // Item action codes
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_COUNT = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_NETWORK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_NODE    = 1'd1;
  localparam int CFG_DATA_W = 16;

  // Field widths
  localparam int ID_W    = 16;
  localparam int ADDR_W  = 2 * ID_W;
  localparam int SLOT_W  = 6;
  localparam int COUNT_W = 7;
  localparam int RANK_W  = 6;

  localparam int DEFAULT_TABLE_DEPTH = 64;

  typedef struct packed {
    logic [1:0]         action;
    logic [SLOT_W-1:0]  slot;
    logic               entry_active;
    logic [ID_W-1:0]    dest_network;
    logic [ID_W-1:0]    dest_node;
    logic [ID_W-1:0]    hop_network;
    logic [ID_W-1:0]    hop_node;
    logic [COUNT_W-1:0] new_count;
    logic [ID_W-1:0]    unreachable_network;
    logic [ID_W-1:0]    unreachable_node;
    logic [RANK_W-1:0]  select_index;
  } item_t;

  typedef struct packed {
    logic            found;
    logic [ID_W-1:0] recipient_network;
    logic [ID_W-1:0] recipient_node;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/route_dependent_recipient_select_top.sv =====
`default_nettype none

// Route table with a dependent-recipient query. Each item started (start high
// while busy is low) gives exactly one result, given on result with done high
// for a single cycle; the receiver cannot stall it, so it must take every
// result as it appears. Items other than queries, and queries while either
// part of the local address is zero or no entry is in use, finish at once:
// done rises the cycle after the start. A query scans the entries in use
// through the table memory, one entry per cycle, and stops at the requested
// match or after the last entry in use. The memory has a single read port
// with a registered read. busy stays high for the scan.
module route_dependent_recipient_select_top #(
  parameter int TABLE_DEPTH = rdrs_pkg::DEFAULT_TABLE_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire rdrs_pkg::item_t               item,
  output logic                               done,
  output rdrs_pkg::result_t                  result,
  input  wire logic                          cfg_we,
  input  wire logic [rdrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rdrs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rdrs_pkg::*;

  localparam int MEM_AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int ENTRY_W = 1 + 2 * ADDR_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  // Entry layout: active flag, next hop, destination
  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0] rd_data;
  logic               mem_we;
  logic [MEM_AW-1:0]  wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [MEM_AW-1:0]  rd_addr;

  logic               state;
  logic [ID_W-1:0]    local_network;
  logic [ID_W-1:0]    local_node;
  logic [COUNT_W-1:0] entry_count;
  logic [COUNT_W-1:0] issue_idx;
  logic               rd_valid;
  logic               rd_last;
  logic [COUNT_W-1:0] match_cnt;
  logic [RANK_W-1:0]  want;
  logic [ADDR_W-1:0]  unreach;

  logic               accept;
  logic               issue;
  logic [ADDR_W-1:0]  local_addr;
  logic               local_ok;
  logic               rd_active;
  logic [ADDR_W-1:0]  rd_hop;
  logic [ADDR_W-1:0]  rd_dest;
  logic               qualify;

  assign accept     = start && (state == ST_IDLE);
  assign busy       = (state == ST_SCAN);
  assign local_addr = {local_network, local_node};
  assign local_ok   = (local_network != '0) && (local_node != '0);
  assign issue      = (state == ST_SCAN) && (issue_idx < entry_count);

  // Table writes happen only while idle, so a scan never overlaps a write
  assign mem_we  = accept && (item.action == ACT_WRITE) && (int'(item.slot) < TABLE_DEPTH);
  assign wr_addr = MEM_AW'(item.slot);
  assign wr_data = {item.entry_active, item.hop_network, item.hop_node,
                    item.dest_network, item.dest_node};
  assign rd_addr = MEM_AW'(issue_idx);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Qualify the entry read in the previous cycle
  assign rd_active = rd_data[ENTRY_W-1];
  assign rd_hop    = rd_data[2*ADDR_W-1:ADDR_W];
  assign rd_dest   = rd_data[ADDR_W-1:0];
  assign qualify   = rd_active && (rd_hop == local_addr) &&
                     (rd_dest != unreach) && (rd_dest != local_addr);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      local_network <= ID_W'(1);
      local_node    <= ID_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOCAL_NETWORK: local_network <= cfg_data;
        CFG_LOCAL_NODE:    local_node    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Query payload, captured at start
  always_ff @(posedge clk) begin
    if (accept) begin
      want    <= item.select_index;
      unreach <= {item.unreachable_network, item.unreachable_node};
    end
  end

  // Control: item handling and scan sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      done        <= 1'b0;
      result      <= '0;
      entry_count <= '0;
      issue_idx   <= '0;
      rd_valid    <= 1'b0;
      rd_last     <= 1'b0;
      match_cnt   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            result    <= '0;
            issue_idx <= '0;
            match_cnt <= '0;
            rd_valid  <= 1'b0;
            rd_last   <= 1'b0;
            if (item.action == ACT_QUERY && local_ok && entry_count != '0) begin
              state <= ST_SCAN;
            end else begin
              done <= 1'b1;
              if (item.action == ACT_COUNT) begin
                if (int'(item.new_count) > TABLE_DEPTH) begin
                  entry_count <= COUNT_W'(TABLE_DEPTH);
                end else begin
                  entry_count <= item.new_count;
                end
              end
            end
          end
        end
        ST_SCAN: begin
          // Advance the read pointer
          rd_valid <= issue;
          rd_last  <= issue && (issue_idx + COUNT_W'(1) == entry_count);
          if (issue) begin
            issue_idx <= issue_idx + COUNT_W'(1);
          end
          // Evaluate the returned entry
          if (rd_valid) begin
            if (qualify && match_cnt == COUNT_W'(want)) begin
              done     <= 1'b1;
              result   <= '{found: 1'b1,
                            recipient_network: rd_dest[ADDR_W-1:ID_W],
                            recipient_node: rd_dest[ID_W-1:0]};
              state    <= ST_IDLE;
              rd_valid <= 1'b0;
            end else begin
              if (qualify) begin
                match_cnt <= match_cnt + COUNT_W'(1);
              end
              if (rd_last) begin
                done     <= 1'b1;
                state    <= ST_IDLE;
                rd_valid <= 1'b0;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rdrs_checker.sv =====
`default_nettype none

module rdrs_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire rdrs_pkg::item_t   item,
  input wire logic              done,
  input wire rdrs_pkg::result_t result
);
  import rdrs_pkg::*;

  // A started item either finishes at once or starts a scan
  a_start_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> done || busy)
    else $error("started item neither finished nor scanning");

  // No result while a scan is still running
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    !(done && busy))
    else $error("result shown while busy");

  // End of a scan always delivers its result
  a_scan_end_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("scan ended without a result");

  // Write and count items never report a match
  a_non_query_empty: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.action != ACT_QUERY |=> done && !result.found)
    else $error("non-query item reported a match");

  // A miss carries a zero recipient
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.found |-> result.recipient_network == '0 &&
                              result.recipient_node == '0)
    else $error("miss with nonzero recipient");

endmodule

bind route_dependent_recipient_select_top rdrs_checker u_rdrs_checker (.*);

`default_nettype wire

// ===== verif/route_dependent_recipient_select_top_tb.sv =====
`default_nettype none

module route_dependent_recipient_select_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rdrs_pkg::*;

  localparam int DEPTH = DEFAULT_TABLE_DEPTH;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = DEPTH + 16;
  localparam int NUM_PHASES = 8;
  localparam logic [1:0] ACT_SPARE = 2'd3;

  // Mirror of the route table; predicts one answer per accepted item and checks it
  class recipient_checker;
    logic [31:0] dest_of [DEPTH];
    logic [32:0] hop_of [DEPTH];
    bit          written [DEPTH];
    int          in_use;
    logic [15:0] own_net;
    logic [15:0] own_node;
    result_t     expected_recipients[$];
    int          errors;

    function new();
      int i;
      for (i = 0; i < DEPTH; i++) begin
        written[i] = 1'b0;
        dest_of[i] = '0;
        hop_of[i] = '0;
      end
      in_use = 0;
      own_net = 16'd1;
      own_node = 16'd1;
      errors = 0;
    endfunction

    function void set_local(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
      if (idx == CFG_LOCAL_NETWORK) begin
        own_net = val;
      end else if (idx == CFG_LOCAL_NODE) begin
        own_node = val;
      end
    endfunction

    // Apply one item to the mirror and return the answer it must give
    function result_t select_recipient(input item_t it);
      result_t     r;
      logic [31:0] own;
      logic [31:0] avoid;
      int          hits;
      int          i;
      r = '0;
      hits = 0;
      case (it.action)
        ACT_WRITE: begin
          dest_of[it.slot] = {it.dest_network, it.dest_node};
          hop_of[it.slot] = {it.entry_active, it.hop_network, it.hop_node};
          written[it.slot] = 1'b1;
        end
        ACT_COUNT: begin
          in_use = (int'(it.new_count) > DEPTH) ? DEPTH : int'(it.new_count);
        end
        ACT_QUERY: begin
          if (own_net != 16'd0 && own_node != 16'd0) begin
            own = {own_net, own_node};
            avoid = {it.unreachable_network, it.unreachable_node};
            for (i = 0; i < in_use && !r.found; i++) begin
              if (hop_of[i][32] && hop_of[i][31:0] == own &&
                  dest_of[i] != avoid && dest_of[i] != own) begin
                if (hits == int'(it.select_index)) begin
                  r = {1'b1, dest_of[i]};
                end
                hits++;
              end
            end
          end
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_item(input item_t it);
      expected_recipients.push_back(select_recipient(it));
    endfunction

    function void check_result(input result_t got);
      result_t want;
      if (expected_recipients.size() == 0) begin
        $error("result with nothing expected: %0h", got);
        errors++;
        return;
      end
      want = expected_recipients.pop_front();
      if (got.found !== want.found) begin
        $error("found: expected %0h, got %0h", want.found, got.found);
        errors++;
      end
      if (got.recipient_network !== want.recipient_network) begin
        $error("recipient_network: expected %0h, got %0h",
               want.recipient_network, got.recipient_network);
        errors++;
      end
      if (got.recipient_node !== want.recipient_node) begin
        $error("recipient_node: expected %0h, got %0h",
               want.recipient_node, got.recipient_node);
        errors++;
      end
    endfunction

    // A query must not scan an in-use entry that was never written
    function bit query_safe();
      int i;
      for (i = 0; i < in_use; i++) begin
        if (!written[i]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function int first_hole();
      int i;
      for (i = 0; i < DEPTH; i++) begin
        if (!written[i]) return i;
      end
      return 0;
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  item_t                 item = '0;
  logic                  done;
  result_t               result;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    cycle_count = 0;
  logic [31:0]           dest_pool [6];
  recipient_checker      ledger = new();

  route_dependent_recipient_select_top #(
    .TABLE_DEPTH(DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (item),
    .done     (done),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL route_dependent_recipient_select_top");
      $finish;
    end
  end

  // Take every result on its single strobe cycle
  always @(posedge clk) begin
    if (!rst && done) begin
      ledger.check_result(result);
    end
  end

  function automatic logic [31:0] own_addr();
    return {ledger.own_net, ledger.own_node};
  endfunction

  function automatic item_t noise_item();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    return raw[$bits(item_t)-1:0];
  endfunction

  function automatic item_t write_item(input int slot_no, input bit act,
                                       input logic [31:0] dest, input logic [31:0] hop);
    item_t it;
    it = noise_item();
    it.action = ACT_WRITE;
    it.slot = SLOT_W'(slot_no);
    it.entry_active = act;
    {it.dest_network, it.dest_node} = dest;
    {it.hop_network, it.hop_node} = hop;
    return it;
  endfunction

  function automatic item_t count_item(input int n);
    item_t it;
    it = noise_item();
    it.action = ACT_COUNT;
    it.new_count = COUNT_W'(n);
    return it;
  endfunction

  function automatic item_t query_item(input logic [31:0] avoid, input int rank);
    item_t it;
    it = noise_item();
    it.action = ACT_QUERY;
    {it.unreachable_network, it.unreachable_node} = avoid;
    it.select_index = RANK_W'(rank);
    return it;
  endfunction

  function automatic logic [31:0] pick_dest();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return dest_pool[$urandom_range(0, 5)];
    if (r < 70) return own_addr();
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_hop();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return own_addr();
    if (r < 85) return own_addr() ^ (32'd1 << $urandom_range(0, 31));
    return $urandom;
  endfunction

  function automatic item_t filled_write(input int slot_no);
    return write_item(slot_no, $urandom_range(0, 99) < 80, pick_dest(), pick_hop());
  endfunction

  // Mostly well-formed table traffic with queries that can hit; a little noise
  function automatic item_t random_item();
    int r;
    int n;
    int rank;
    logic [31:0] avoid;
    item_t it;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      it = noise_item();
      it.action = ACT_SPARE;
      return it;
    end
    if (r < 40) return filled_write($urandom_range(0, DEPTH - 1));
    if (r < 52) begin
      n = $urandom_range(0, 99);
      if (n < 50) return count_item($urandom_range(0, DEPTH));
      if (n < 70) return count_item($urandom_range(0, 12));
      if (n < 85) return count_item(DEPTH);
      return count_item($urandom_range(DEPTH + 1, 127));
    end
    // fill the lowest unwritten in-use entry before any query may scan it
    if (!ledger.query_safe()) return filled_write(ledger.first_hole());
    n = $urandom_range(0, 99);
    if (n < 50) avoid = dest_pool[$urandom_range(0, 5)];
    else if (n < 60) avoid = own_addr();
    else avoid = $urandom;
    n = $urandom_range(0, 99);
    if (n < 60) rank = $urandom_range(0, 7);
    else if (n < 85) rank = $urandom_range(0, 31);
    else rank = $urandom_range(0, 63);
    return query_item(avoid, rank);
  endfunction

  function automatic void refill_pool();
    int i;
    for (i = 0; i < 6; i++) dest_pool[i] = $urandom;
    if ($urandom_range(0, 1) == 1) dest_pool[0] = 32'h0;
    if ($urandom_range(0, 1) == 1) dest_pool[1] = 32'hFFFF_FFFF;
  endfunction

  // Present an item and hold it until the block takes it
  task automatic send_item(input item_t it);
    start <= 1'b1;
    item <= it;
    do begin
      @(posedge clk);
    end while (busy);
    ledger.note_item(it);
  endtask

  task automatic pause(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Hold off until every expected result has come and the block is idle
  task automatic drain();
    start <= 1'b0;
    while (ledger.expected_recipients.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic set_address(input logic [15:0] net, input logic [15:0] node);
    cfg_we <= 1'b1;
    cfg_index <= CFG_LOCAL_NETWORK;
    cfg_data <= net;
    @(posedge clk);
    cfg_index <= CFG_LOCAL_NODE;
    cfg_data <= node;
    @(posedge clk);
    cfg_we <= 1'b0;
    ledger.set_local(CFG_LOCAL_NETWORK, net);
    ledger.set_local(CFG_LOCAL_NODE, node);
  endtask

  initial begin
    logic [15:0] phase_net [NUM_PHASES];
    logic [15:0] phase_node [NUM_PHASES];
    int          phase_idle [NUM_PHASES];
    int          phase_len [NUM_PHASES];
    logic [31:0] own;
    int          p;
    int          k;

    phase_net  = '{16'hFFFF, 16'h0001, 16'h0000, 16'hFFFF, 16'h0007, 16'h0, 16'h0, 16'h0001};
    phase_node = '{16'hFFFF, 16'hFFFF, 16'h0005, 16'h0001, 16'h0000, 16'h0, 16'h0, 16'h0001};
    phase_idle = '{0, 45, 0, 19, 45, 0, 45, 19};
    phase_len  = '{300, 300, 40, 300, 40, 300, 300, 250};

    refill_pool();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, extremes, exclusions, saturation, ranks, spare action
    own = own_addr();
    send_item(query_item(32'h0, 0));
    send_item(write_item(0, 1'b1, 32'hFFFF_FFFF, own));
    send_item(write_item(1, 1'b1, 32'h0000_0000, own));
    send_item(write_item(2, 1'b0, 32'h0005_0005, own));
    send_item(write_item(3, 1'b1, own, own));
    send_item(write_item(4, 1'b1, 32'h1234_5678, 32'h0001_0002));
    send_item(write_item(5, 1'b1, 32'hABCD_0001, own));
    send_item(write_item(DEPTH - 1, 1'b1, 32'h8000_8000, own));
    send_item(count_item(127));
    send_item(count_item(6));
    send_item(query_item(32'h0000_0000, 0));
    send_item(query_item(32'hFFFF_FFFF, 0));
    send_item(query_item(32'h0009_0009, 1));
    send_item(query_item(32'h0009_0009, 2));
    send_item(query_item(32'h0009_0009, 3));
    send_item(query_item(32'hABCD_0001, 63));
    send_item(noise_item() | {ACT_SPARE, {($bits(item_t) - 2){1'b0}}});
    send_item(count_item(0));
    send_item(query_item(32'h0, 0));
    send_item(count_item(6));
    send_item(query_item(own, 1));

    // Random phases, each under its own local address
    for (p = 0; p < NUM_PHASES; p++) begin
      drain();
      if (p == 5 || p == 6) begin
        phase_net[p] = 16'($urandom_range(1, 65535));
        phase_node[p] = 16'($urandom_range(1, 65535));
      end
      set_address(phase_net[p], phase_node[p]);
      refill_pool();
      for (k = 0; k < phase_len[p]; k++) begin
        if ($urandom_range(0, 149) == 0) drain();
        if ($urandom_range(0, 99) < phase_idle[p]) begin
          if ($urandom_range(0, 4) == 0) pause($urandom_range(5, 70));
          else pause($urandom_range(1, 4));
        end
        send_item(random_item());
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (ledger.errors == 0 && ledger.expected_recipients.size() == 0) begin
      $display("PASS route_dependent_recipient_select_top");
    end else begin
      $display("FAIL route_dependent_recipient_select_top");
    end
    $finish;
  end

endmodule

`default_nettype wire
